>>> hw/rtl/sjtg_pkg.sv
package sjtg_pkg;

	// Field widths of one beat
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned FIRST_W  = 21;
	localparam int unsigned SECOND_W = 15;
	localparam int unsigned USED_W   = 2;
	localparam int unsigned IN_W     = 16;
	localparam int unsigned OUT_W    = 40;

	// Operand widths inside the pipe
	localparam int unsigned DIFF_W  = 16;
	localparam int unsigned SCALE_W = 8;
	localparam int unsigned ROW_W   = 6;
	localparam int unsigned HDIFF_W = 7;
	localparam int unsigned ROWP_W  = 20;

	// Bytes consumed
	localparam logic [USED_W-1:0] USED_ONE = 2'd1;
	localparam logic [USED_W-1:0] USED_TWO = 2'd2;

	// Fixed glyph offsets
	localparam logic [FIRST_W-1:0] FW_SPACE    = 21'h000467;
	localparam logic [FIRST_W-1:0] FW_QUESTION = 21'h000987;

	// One kanji row: 11055 plus one glyph of 165
	localparam logic [13:0] ROW_STEP = 14'd11220;

	// Half-width operands: offset = d * k + base
	typedef struct packed {
		logic [HDIFF_W-1:0]  d;
		logic [SCALE_W-1:0]  k;
		logic [SECOND_W-1:0] base;
	} half_op_t;

	// Stage 1 payload: first = d*k - m*ROW_STEP + add, second = td*tk + tadd
	typedef struct packed {
		logic                full;
		logic [USED_W-1:0]   used;
		logic [DIFF_W-1:0]   d;
		logic [SCALE_W-1:0]  k;
		logic [ROW_W-1:0]    m;
		logic [FIRST_W-1:0]  add;
		logic [HDIFF_W-1:0]  td;
		logic [SCALE_W-1:0]  tk;
		logic [SECOND_W-1:0] tadd;
	} s1_pay_t;

	// Stage 2 payload: products
	typedef struct packed {
		logic                full;
		logic [USED_W-1:0]   used;
		logic [FIRST_W-1:0]  p;
		logic [ROWP_W-1:0]   q;
		logic [FIRST_W-1:0]  add;
		logic [SECOND_W-1:0] tp;
		logic [SECOND_W-1:0] tadd;
	} s2_pay_t;

	// Stage 3 payload: final result
	typedef struct packed {
		logic                full;
		logic [USED_W-1:0]   used;
		logic [FIRST_W-1:0]  first;
		logic [SECOND_W-1:0] second;
	} s3_pay_t;

endpackage

>>> hw/rtl/sjtg_decode.sv
module sjtg_decode (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [sjtg_pkg::BYTE_W-1:0]       lead,
	input  logic [sjtg_pkg::BYTE_W-1:0]       trail,
	output logic                              valid_s1,
	output sjtg_pkg::s1_pay_t                 pay_s1
);

	function automatic logic is_half(input logic [7:0] b);
		return (b >= 8'h20 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hDF);
	endfunction

	// Three linear segments of the half-width table
	function automatic sjtg_pkg::half_op_t half_op(input logic [7:0] b);
		sjtg_pkg::half_op_t r;
		if (b <= 8'h63) begin
			r.d    = 7'(b - 8'h20);
			r.k    = 8'd126;
			r.base = 15'h1346;
		end else if (b <= 8'h7E) begin
			r.d    = 7'(b - 8'h64);
			r.k    = 8'd127;
			r.base = 15'h34BF;
		end else begin
			r.d    = 7'(b - 8'hA1);
			r.k    = 8'd129;
			r.base = 15'h4226;
		end
		return r;
	endfunction

	logic [15:0]        code;
	sjtg_pkg::s1_pay_t  nxt;
	sjtg_pkg::half_op_t lop;
	sjtg_pkg::half_op_t top;

	assign code = {lead, trail};
	assign lop  = half_op(lead);
	assign top  = half_op(trail);

	// Range decode into multiply operands
	always_comb begin
		nxt = '0;
		if (is_half(lead)) begin
			nxt.full = 1'b0;
			nxt.d    = 16'(lop.d);
			nxt.k    = lop.k;
			nxt.add  = 21'(lop.base);
			if (is_half(trail)) begin
				nxt.used = sjtg_pkg::USED_TWO;
				nxt.td   = top.d;
				nxt.tk   = top.k;
				nxt.tadd = top.base;
			end else begin
				nxt.used = sjtg_pkg::USED_ONE;
			end
		end else begin
			nxt.full = 1'b1;
			nxt.used = sjtg_pkg::USED_TWO;
			nxt.add  = sjtg_pkg::FW_SPACE;
			if (code >= 16'h8140 && code <= 16'h83D6) begin
				// symbols, Latin, kana, Greek
				nxt.d = code - 16'h8140;
				nxt.k = 8'd164;
				if (code <= 16'h817E)      nxt.add = 21'(1127);
				else if (code <= 16'h81AC) nxt.add = 21'(963);
				else if (code <= 16'h81BF) nxt.add = 21'(-841);
				else if (code <= 16'h81CE) nxt.add = 21'(-2153);
				else if (code <= 16'h81E8) nxt.add = 21'(-3957);
				else if (code <= 16'h81F7) nxt.add = 21'(-5105);
				else if (code == 16'h81FC) nxt.add = 21'(-5761);
				else if (code <= 16'h8258) nxt.add = 21'(-19209);
				else if (code <= 16'h8279) nxt.add = 21'(-20357);
				else if (code <= 16'h829A) nxt.add = 21'(-21505);
				else if (code <= 16'h82F1) nxt.add = 21'(-22161);
				else if (code <= 16'h837E) nxt.add = 21'(-34953);
				else if (code <= 16'h8396) nxt.add = 21'(-35117);
				else if (code <= 16'h83B6) nxt.add = 21'(-36429);
				else if (code >= 16'h83BF) nxt.add = 21'(-37741);
				else                       nxt.add = '0;
			end else if (code >= 16'h8440 && code <= 16'h84BE) begin
				// Cyrillic and box drawing
				nxt.d = code - 16'h8440;
				nxt.k = 8'd165;
				if (code <= 16'h8460)      nxt.add = 21'(70992);
				else if (code <= 16'h847E) nxt.add = 21'(68517);
				else if (code <= 16'h8491) nxt.add = 21'(68352);
				else if (code >= 16'h849F) nxt.add = 21'(66207);
				else                       nxt.add = '0;
			end else if (code >= 16'h8740 && code <= 16'h879E) begin
				nxt.add = sjtg_pkg::FW_QUESTION;
			end else if (code >= 16'h889F && code <= 16'h88FC) begin
				nxt.d   = code - 16'h889F;
				nxt.k   = 8'd165;
				nxt.add = 21'(87162);
			end else if ((code >= 16'h8940 && code <= 16'h9872) ||
			             (code >= 16'h989F && code <= 16'h9FFC)) begin
				// level-1 and level-2 kanji; trail 0x7F is a hole
				if (trail != 8'h7F) begin
					nxt.d   = code - 16'h889F;
					nxt.k   = 8'd165;
					nxt.m   = 6'(lead - 8'h88);
					nxt.add = (code <= 16'h9872) ? 21'(87162) : 21'(80067);
					if (trail <= 8'h7E)
						nxt.add = nxt.add + 21'(165);
				end
			end else if (code >= 16'hE040 && code <= 16'hEAA4) begin
				if (trail != 8'h7F) begin
					nxt.d   = code - 16'h889F;
					nxt.k   = 8'd165;
					nxt.m   = 6'(lead - 8'hC9);
					nxt.add = (trail <= 8'h7E) ? 21'(-2634348) : 21'(-2634513);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= nxt;
		end
	end

endmodule

>>> hw/rtl/sjtg_mult.sv
module sjtg_mult (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_s1,
	input  sjtg_pkg::s1_pay_t pay_s1,
	output logic              valid_s2,
	output sjtg_pkg::s2_pay_t pay_s2
);

	logic [23:0] prod;
	logic [19:0] rowp;
	logic [14:0] tprod;

	// Products; the row product uses the constant ROW_STEP
	assign prod  = 24'(pay_s1.d) * 24'(pay_s1.k);
	assign rowp  = 20'(pay_s1.m) * 20'(sjtg_pkg::ROW_STEP);
	assign tprod = 15'(pay_s1.td) * 15'(pay_s1.tk);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s2.full <= pay_s1.full;
			pay_s2.used <= pay_s1.used;
			pay_s2.p    <= prod[20:0];
			pay_s2.q    <= rowp;
			pay_s2.add  <= pay_s1.add;
			pay_s2.tp   <= tprod;
			pay_s2.tadd <= pay_s1.tadd;
		end
	end

endmodule

>>> hw/rtl/sjtg_sum.sv
module sjtg_sum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_s2,
	input  sjtg_pkg::s2_pay_t pay_s2,
	output logic              valid_s3,
	output sjtg_pkg::s3_pay_t pay_s3
);

	// Offsets wrap modulo 2^21 and 2^15
	logic [20:0] first;
	logic [14:0] second;

	assign first  = pay_s2.p - 21'(pay_s2.q) + pay_s2.add;
	assign second = pay_s2.tp + pay_s2.tadd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s3.full   <= pay_s2.full;
			pay_s3.used   <= pay_s2.used;
			pay_s3.first  <= first;
			pay_s3.second <= second;
		end
	end

endmodule

>>> hw/rtl/sjis_to_glyph_offset.sv
// Shift-JIS byte pair to glyph file offsets.
// Input stream: one beat per lead/trail pair; output stream: one beat per
// input beat, in order, with the glyph offsets and the number of bytes used.
// A half-width lead gives its own offset and, if the trail is half-width
// too, the trail offset with bytes_used 2; otherwise bytes_used 1.
// Any other lead is decoded as a full-width code; codes outside the decoded
// ranges give the full-width space glyph.
// Pipeline: decode, multiply, sum - three register stages.
// A beat passes the decode, multiply and sum registers in order before it
// is offered. Throughput: one beat per cycle while m_axis_tready is high.
// Each stage advances when the next one is empty or moving, so s_axis_tready
// drops only when all three stages hold data and m_axis_tready is low; no
// beat is dropped or repeated during a stall.
// Reset clears all valid bits; the pipe comes up empty and ready.
module sjis_to_glyph_offset (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // lead_byte[7:0], trail_byte[15:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // bytes_used[1:0], first_offset[22:2],
	                                   // second_offset[37:23], zero[39:38]
	output logic        m_axis_tuser   // is_full_width[0]
);

	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	sjtg_pkg::s1_pay_t pay_s1;
	sjtg_pkg::s2_pay_t pay_s2;
	sjtg_pkg::s3_pay_t pay_s3;
	logic              en1;
	logic              en2;
	logic              en3;

	// Stage advance chain
	assign en3 = !valid_s3 || m_axis_tready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_axis_tready = en1;

	sjtg_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.in_valid (s_axis_tvalid),
		.lead     (s_axis_tdata[7:0]),
		.trail    (s_axis_tdata[15:8]),
		.valid_s1 (valid_s1),
		.pay_s1   (pay_s1)
	);

	sjtg_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.pay_s1   (pay_s1),
		.valid_s2 (valid_s2),
		.pay_s2   (pay_s2)
	);

	sjtg_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.pay_s2   (pay_s2),
		.valid_s3 (valid_s3),
		.pay_s3   (pay_s3)
	);

	// Output beat packing
	assign m_axis_tvalid = valid_s3;
	assign m_axis_tuser  = pay_s3.full;
	assign m_axis_tdata  = {2'b00, pay_s3.second, pay_s3.first, pay_s3.used};

endmodule

>>> hw/rtl/sjtg_checker.sv
module sjtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// Stalled output beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output beat changed during stall");

	// An empty output stage never back-pressures the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// Full-width beats use two bytes and no trail glyph
	a_full_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[1:0] == 2'd2 && m_axis_tdata[37:23] == 15'd0)
		else $error("bad full-width beat");

	// Byte count is one or two; a single byte carries no trail glyph
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[1:0] == 2'd2) ||
			(m_axis_tdata[1:0] == 2'd1 && m_axis_tdata[37:23] == 15'd0 && !m_axis_tuser))
		else $error("bad bytes_used");

	// Half-width lead offsets stay within 15 bits; padding is zero
	a_half_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			m_axis_tdata[22:17] == 6'd0 && m_axis_tdata[39:38] == 2'd0)
		else $error("half-width offset out of range");

endmodule

bind sjis_to_glyph_offset sjtg_checker u_sjtg_checker (.*);
